@@ design/sssd_pkg.sv @@
// Shared types, constants and the digit glyph table for the seven-segment scan driver.
`timescale 1ns / 1ps

package sssd_pkg;

    // Request kinds
    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_NUMBER = 2'd1,
        CMD_DIGITS = 2'd2,
        CMD_RAW    = 2'd3
    } cmd_t;

    localparam logic [15:0] HOLD_RESET = 16'd1500;

    // Reciprocal constants: floor(n / d) == (n * RECIP) >> SHIFT for any 16-bit n
    localparam logic [32:0] RECIP_10    = 33'd52429;
    localparam logic [32:0] RECIP_100   = 33'd83887;
    localparam logic [32:0] RECIP_1000  = 33'd67109;
    localparam logic [32:0] RECIP_10000 = 33'd107375;

    // Decimal quotients of the displayed number
    typedef struct packed {
        logic [2:0]  q10000;
        logic [6:0]  q1000;
        logic [9:0]  q100;
        logic [12:0] q10;
    } quot_t;

    // Segment byte for a digit code: a..g on bits 7..1, DP on bit 0, blank above 9
    function automatic logic [7:0] glyph(input logic [7:0] code, input logic point);
        logic [7:0] seg;
        unique case (code)
            8'd0:    seg = 8'hFC;
            8'd1:    seg = 8'h60;
            8'd2:    seg = 8'hDA;
            8'd3:    seg = 8'hF2;
            8'd4:    seg = 8'h66;
            8'd5:    seg = 8'hB6;
            8'd6:    seg = 8'hBE;
            8'd7:    seg = 8'hE0;
            8'd8:    seg = 8'hFE;
            8'd9:    seg = 8'hF6;
            default: seg = 8'h00;
        endcase
        return seg | {7'd0, point};
    endfunction

endpackage

@@ design/sssd_decimal.sv @@
// Reciprocal multipliers that split a 16-bit number into its decimal quotients.
`timescale 1ns / 1ps

module sssd_decimal (
    input  logic [15:0]    number,
    output sssd_pkg::quot_t quot
);
    import sssd_pkg::*;

    logic [32:0] prod_10;
    logic [32:0] prod_100;
    logic [32:0] prod_1000;
    logic [32:0] prod_10000;

    // Four independent 16x17 multiplies
    assign prod_10    = 33'(number) * RECIP_10;
    assign prod_100   = 33'(number) * RECIP_100;
    assign prod_1000  = 33'(number) * RECIP_1000;
    assign prod_10000 = 33'(number) * RECIP_10000;

    // Quotients are the upper bits
    assign quot.q10    = prod_10[31:19];
    assign quot.q100   = prod_100[32:23];
    assign quot.q1000  = prod_1000[32:26];
    assign quot.q10000 = prod_10000[32:30];

endmodule

@@ design/seven_segment_scan_driver.sv @@
// Four-digit multiplexed seven-segment driver: update buffering, hold timer, scan frames.
`timescale 1ns / 1ps

// One request is accepted per cycle unless a tick waits for room in the output register;
// requests pass an input register and a quotient register, and take effect in order
// as they leave the quotient register, where a tick loads its frame into the output register.
// The reciprocal multipliers sit between the input and quotient registers.
// Reset clears buffers, flags, timer and scan position; hold_ticks resets to 1500.

module seven_segment_scan_driver (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic [15:0] number,
    input  logic [31:0] digit_bytes,
    input  logic [3:0]  point_mask,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] frame,
    output logic [1:0]  scan_digit
);
    import sssd_pkg::*;

    // Configuration
    logic [15:0] hold_ticks_reg;

    // Input stage
    logic        v1_reg;
    cmd_t        cmd1_reg;
    logic [15:0] number1_reg;
    logic [31:0] bytes1_reg;
    logic [3:0]  pm1_reg;

    // Quotient stage
    logic        v2_reg;
    cmd_t        cmd2_reg;
    quot_t       quot2_reg;
    logic [31:0] bytes2_reg;
    logic [3:0]  pm2_reg;
    quot_t       quot1;

    // Display state
    logic [7:0]  shown_reg [4];
    logic [7:0]  shown_next [4];
    logic [7:0]  waiting_reg [4];
    logic [7:0]  waiting_next [4];
    logic        upd_reg;
    logic        upd_next;
    logic [15:0] hold_reg;
    logic [15:0] hold_next;
    logic [1:0]  scan_reg;
    logic [1:0]  scan_next;

    // Output register
    logic        ov_reg;
    logic        ov_next;
    logic [15:0] frame_reg;
    logic [15:0] frame_next;
    logic [1:0]  sdig_reg;

    logic        out_free;
    logic        adv1;
    logic        adv2;
    logic        is_tick2;
    logic [15:0] hold_dec;
    logic [7:0]  sel_byte;
    logic [3:0]  dig [4];
    logic [6:0]  rem1000;
    logic [9:0]  rem100;
    logic [12:0] rem10;

    // Stage handshakes; a tick needs room in the output register
    assign out_free = !ov_reg || out_ready;
    assign is_tick2 = (cmd2_reg == CMD_TICK);
    assign adv2     = v2_reg && (!is_tick2 || out_free);
    assign adv1     = v1_reg && (!v2_reg || adv2);
    assign in_ready = !v1_reg || adv1;

    assign out_valid  = ov_reg;
    assign frame      = frame_reg;
    assign scan_digit = sdig_reg;

    sssd_decimal u_decimal (
        .number (number1_reg),
        .quot   (quot1)
    );

    // Decimal digits from adjacent quotients: q_k - 10 * q_(k+1)
    assign rem1000 = quot2_reg.q1000 - (7'({quot2_reg.q10000, 3'b000})
                                        + 7'({quot2_reg.q10000, 1'b0}));
    assign rem100  = quot2_reg.q100 - ({quot2_reg.q1000, 3'b000}
                                       + 10'({quot2_reg.q1000, 1'b0}));
    assign rem10   = quot2_reg.q10 - ({quot2_reg.q100, 3'b000}
                                      + 13'({quot2_reg.q100, 1'b0}));
    assign dig[3]  = {1'b0, quot2_reg.q10000};
    assign dig[2]  = rem1000[3:0];
    assign dig[1]  = rem100[3:0];
    assign dig[0]  = rem10[3:0];

    assign hold_dec = (hold_reg != 16'd0) ? hold_reg - 16'd1 : 16'd0;
    assign sel_byte = ~(8'd3 << {scan_reg, 1'b0});

    // Next display state and frame
    always_comb
    begin
        shown_next   = shown_reg;
        waiting_next = waiting_reg;
        upd_next     = upd_reg;
        hold_next    = hold_reg;
        scan_next    = scan_reg;
        frame_next   = frame_reg;
        if (adv2)
        begin
            unique case (cmd2_reg)
                CMD_NUMBER:
                begin
                    for (int k = 0; k < 4; k++)
                        waiting_next[k] = glyph({4'd0, dig[k]}, k == 2);
                    upd_next = 1'b1;
                end
                CMD_DIGITS:
                begin
                    for (int k = 0; k < 4; k++)
                        waiting_next[k] = glyph(bytes2_reg[8*k +: 8], pm2_reg[k]);
                    upd_next = 1'b1;
                end
                CMD_RAW:
                begin
                    for (int k = 0; k < 4; k++)
                        waiting_next[k] = bytes2_reg[8*k +: 8];
                    upd_next = 1'b1;
                end
                CMD_TICK:
                begin
                    hold_next = hold_dec;
                    if (upd_reg && hold_dec == 16'd0)
                    begin
                        shown_next = waiting_reg;
                        upd_next   = 1'b0;
                        hold_next  = hold_ticks_reg;
                    end
                    frame_next = {sel_byte, shown_next[scan_reg]};
                    scan_next  = scan_reg + 2'd1;
                end
                default:
                begin
                    upd_next = upd_reg;
                end
            endcase
        end
    end

    // Output valid
    always_comb
    begin
        if (adv2 && is_tick2)
            ov_next = 1'b1;
        else if (out_ready)
            ov_next = 1'b0;
        else
            ov_next = ov_reg;
    end

    // Control and display state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_ticks_reg <= HOLD_RESET;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            ov_reg         <= 1'b0;
            upd_reg        <= 1'b0;
            hold_reg       <= 16'd0;
            scan_reg       <= 2'd0;
            for (int k = 0; k < 4; k++)
            begin
                shown_reg[k]   <= 8'd0;
                waiting_reg[k] <= 8'd0;
            end
        end
        else
        begin
            if (cfg_write)
                hold_ticks_reg <= cfg_data;
            if (in_ready)
                v1_reg <= in_valid;
            if (!v2_reg || adv2)
                v2_reg <= adv1;
            ov_reg      <= ov_next;
            upd_reg     <= upd_next;
            hold_reg    <= hold_next;
            scan_reg    <= scan_next;
            shown_reg   <= shown_next;
            waiting_reg <= waiting_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            cmd1_reg    <= cmd_t'(cmd);
            number1_reg <= number;
            bytes1_reg  <= digit_bytes;
            pm1_reg     <= point_mask;
        end
        if (adv1)
        begin
            cmd2_reg   <= cmd1_reg;
            quot2_reg  <= quot1;
            bytes2_reg <= bytes1_reg;
            pm2_reg    <= pm1_reg;
        end
        if (adv2 && is_tick2)
        begin
            frame_reg <= frame_next;
            sdig_reg  <= scan_reg;
        end
    end

endmodule

@@ sim/seven_segment_scan_driver_test.sv @@
// Self-checking testbench for the four-digit seven-segment scan driver.
`timescale 1ns / 1ps

module seven_segment_scan_driver_test;

    import sssd_pkg::*;

    localparam int STALL_LIMIT  = 2000;  // cycles with no request or frame moving
    localparam int DRAIN_CYCLES = 4;     // two pipeline stages plus margin
    localparam int ITEMS_PER_PHASE = 64;

    // Segment patterns for digits 0..9, a..g on bits 7..1
    localparam logic [7:0] DIGIT_SEGS [10] = '{
        8'hFC, 8'h60, 8'hDA, 8'hF2, 8'h66, 8'hB6, 8'hBE, 8'hE0, 8'hFE, 8'hF6
    };

    // Hold timer settings, one per random phase; the large ones come last
    localparam logic [15:0] HOLD_PLAN [6] = '{
        16'd1, 16'd3, 16'd0, 16'd2, 16'hFFFF, HOLD_RESET
    };

    typedef struct packed {
        logic [15:0] frame;
        logic [1:0]  digit;
    } scan_frame_t;

    // Directed request row; fixed frames are typed in where obvious
    typedef struct packed {
        cmd_t        kind;
        logic [15:0] num;
        logic [31:0] bytes;
        logic [3:0]  pts;
        logic        fixed;
        logic [15:0] frame;
        logic [1:0]  digit;
    } plan_row_t;

    localparam int PLAN_LEN = 24;
    localparam plan_row_t PLAN [PLAN_LEN] = '{
        // blank display after reset, one frame per position
        '{CMD_TICK,   16'd0,     32'h0,         4'h0, 1'b1, 16'hFC00, 2'd0},
        '{CMD_TICK,   16'd0,     32'h0,         4'h0, 1'b1, 16'hF300, 2'd1},
        '{CMD_TICK,   16'd0,     32'h0,         4'h0, 1'b1, 16'hCF00, 2'd2},
        '{CMD_TICK,   16'd0,     32'h0,         4'h0, 1'b1, 16'h3F00, 2'd3},
        // all segments lit
        '{CMD_RAW,    16'd0,     32'hFFFFFFFF,  4'h0, 1'b0, 16'h0,    2'd0},
        '{CMD_TICK,   16'd0,     32'h0,         4'h0, 1'b1, 16'hFCFF, 2'd0},
        // largest number
        '{CMD_NUMBER, 16'hFFFF,  32'h0,         4'h0, 1'b0, 16'h0,    2'd0},
        '{CMD_TICK,   16'd0,     32'h0,         4'h0, 1'b0, 16'h0,    2'd0},
        '{CMD_TICK,   16'd0,     32'h0,         4'h0, 1'b0, 16'h0,    2'd0},
        // codes above 9 blank, points still lit
        '{CMD_DIGITS, 16'd0,     32'h090A00FF,  4'hF, 1'b0, 16'h0,    2'd0},
        '{CMD_TICK,   16'd0,     32'h0,         4'h0, 1'b0, 16'h0,    2'd0},
        '{CMD_TICK,   16'd0,     32'h0,         4'h0, 1'b1, 16'hFC01, 2'd0},
        // back-to-back updates: only the last one shows
        '{CMD_NUMBER, 16'd0,     32'h0,         4'h0, 1'b0, 16'h0,    2'd0},
        '{CMD_RAW,    16'd0,     32'h12345678,  4'h0, 1'b0, 16'h0,    2'd0},
        '{CMD_NUMBER, 16'd12345, 32'h0,         4'h0, 1'b0, 16'h0,    2'd0},
        '{CMD_TICK,   16'd0,     32'h0,         4'h0, 1'b0, 16'h0,    2'd0},
        '{CMD_DIGITS, 16'd0,     32'h0,         4'h0, 1'b0, 16'h0,    2'd0},
        '{CMD_TICK,   16'd0,     32'h0,         4'h0, 1'b0, 16'h0,    2'd0},
        '{CMD_TICK,   16'd0,     32'h0,         4'h0, 1'b0, 16'h0,    2'd0},
        '{CMD_RAW,    16'd0,     32'h0,         4'h0, 1'b0, 16'h0,    2'd0},
        '{CMD_TICK,   16'd0,     32'h0,         4'h0, 1'b1, 16'hFC00, 2'd0},
        '{CMD_NUMBER, 16'd9999,  32'h0,         4'h0, 1'b0, 16'h0,    2'd0},
        '{CMD_DIGITS, 16'd0,     32'h07080906,  4'h5, 1'b0, 16'h0,    2'd0},
        '{CMD_TICK,   16'd0,     32'h0,         4'h0, 1'b0, 16'h0,    2'd0}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic [15:0] cfg_data = 16'd0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  cmd = CMD_TICK;
    logic [15:0] number = 16'd0;
    logic [31:0] digit_bytes = 32'd0;
    logic [3:0]  point_mask = 4'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [15:0] frame;
    logic [1:0]  scan_digit;

    // Predicted display state
    logic [7:0]  shown_seg [4];
    logic [7:0]  pending_seg [4];
    logic        pending_flag;
    logic [15:0] hold_left;
    logic [1:0]  scan_pos;
    logic [15:0] hold_setting;

    scan_frame_t frames_due [$];
    int          error_count = 0;
    int          quiet_cycles = 0;
    bit          steady = 1'b0;

    seven_segment_scan_driver dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .number      (number),
        .digit_bytes (digit_bytes),
        .point_mask  (point_mask),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .frame       (frame),
        .scan_digit  (scan_digit)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Segment byte of a digit code; codes above 9 are blank
    function automatic logic [7:0] code_segments(input int code, input logic point);
        logic [7:0] seg;
        seg = (code <= 9) ? DIGIT_SEGS[code] : 8'h00;
        return seg | {7'd0, point};
    endfunction

    // Advance the display model by one request; returns 1 when a frame is due
    function automatic bit display_step(input cmd_t kind, input logic [15:0] num,
                                        input logic [31:0] bytes, input logic [3:0] pts,
                                        output scan_frame_t due);
        int n;
        due = '0;
        n = num;
        case (kind)
            CMD_NUMBER:
            begin
                pending_seg[3] = code_segments((n / 10000) % 10, 1'b0);
                pending_seg[2] = code_segments((n / 1000) % 10, 1'b1);
                pending_seg[1] = code_segments((n / 100) % 10, 1'b0);
                pending_seg[0] = code_segments((n / 10) % 10, 1'b0);
                pending_flag = 1'b1;
                return 1'b0;
            end
            CMD_DIGITS:
            begin
                for (int k = 0; k < 4; k++)
                    pending_seg[k] = code_segments(int'(bytes[8*k +: 8]), pts[k]);
                pending_flag = 1'b1;
                return 1'b0;
            end
            CMD_RAW:
            begin
                for (int k = 0; k < 4; k++)
                    pending_seg[k] = bytes[8*k +: 8];
                pending_flag = 1'b1;
                return 1'b0;
            end
            default:
            begin
                // scan tick: count down, maybe take the pending update, emit a frame
                if (hold_left != 16'd0)
                    hold_left = hold_left - 16'd1;
                if (pending_flag && hold_left == 16'd0)
                begin
                    for (int k = 0; k < 4; k++)
                        shown_seg[k] = pending_seg[k];
                    pending_flag = 1'b0;
                    hold_left = hold_setting;
                end
                due.frame = (16'hFF00 ^ (16'h0300 << (2 * scan_pos))) | {8'h00, shown_seg[scan_pos]};
                due.digit = scan_pos;
                scan_pos = scan_pos + 2'd1;
                return 1'b1;
            end
        endcase
    endfunction

    // Drive one request and record the frame it should produce
    task automatic send_request(input cmd_t kind, input logic [15:0] num,
                                input logic [31:0] bytes, input logic [3:0] pts,
                                input logic fixed, input logic [15:0] fixed_frame,
                                input logic [1:0] fixed_digit);
        scan_frame_t due;
        bit          has_frame;
        while (!steady && $urandom_range(99) < 8)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        cmd         <= kind;
        number      <= num;
        digit_bytes <= bytes;
        point_mask  <= pts;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        has_frame = display_step(kind, num, bytes, pts, due);
        if (has_frame)
        begin
            if (fixed)
            begin
                due.frame = fixed_frame;
                due.digit = fixed_digit;
            end
            frames_due.push_back(due);
        end
    endtask

    // Wait for the block to go idle, then load a new hold setting
    task automatic write_hold(input logic [15:0] value);
        in_valid <= 1'b0;
        while (frames_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        hold_setting = value;
    endtask

    // Frame checker and output back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        scan_frame_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (frames_due.size() == 0)
                begin
                    report_mismatch($sformatf("frame %h digit %0d with none expected",
                                              frame, scan_digit));
                end
                else
                begin
                    want = frames_due.pop_front();
                    if (frame !== want.frame)
                        report_mismatch($sformatf("frame %h, expected %h", frame, want.frame));
                    if (scan_digit !== want.digit)
                        report_mismatch($sformatf("scan_digit %0d, expected %0d",
                                                  scan_digit, want.digit));
                end
            end
            out_ready <= steady || ($urandom_range(99) >= 8);
        end
    end

    // Watchdog on cycles with no transfer on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // Stimulus
    initial
    begin
        cmd_t        kind;
        logic [31:0] bytes;
        int          pick;

        for (int k = 0; k < 4; k++)
        begin
            shown_seg[k]   = 8'h00;
            pending_seg[k] = 8'h00;
        end
        pending_flag = 1'b0;
        hold_left    = 16'd0;
        scan_pos     = 2'd0;
        hold_setting = HOLD_RESET;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part runs with no hold so every update shows at once
        write_hold(16'd0);
        for (int r = 0; r < PLAN_LEN; r++)
            send_request(PLAN[r].kind, PLAN[r].num, PLAN[r].bytes, PLAN[r].pts,
                         PLAN[r].fixed, PLAN[r].frame, PLAN[r].digit);

        // random phases, one hold setting each; phase 2 runs without idling
        for (int p = 0; p < 6; p++)
        begin
            write_hold(HOLD_PLAN[p]);
            steady = (p == 2);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                pick = $urandom_range(99);
                if (pick < 55)
                    kind = CMD_TICK;
                else if (pick < 70)
                    kind = CMD_NUMBER;
                else if (pick < 85)
                    kind = CMD_DIGITS;
                else
                    kind = CMD_RAW;
                bytes = $urandom;
                // digit codes mostly in or just past the decimal range
                if (kind == CMD_DIGITS && $urandom_range(99) < 80)
                    for (int k = 0; k < 4; k++)
                        bytes[8*k +: 8] = 8'($urandom_range(11));
                send_request(kind, 16'($urandom_range(65535)), bytes, 4'($urandom_range(15)),
                             1'b0, 16'h0, 2'd0);
            end
        end
        steady = 1'b0;
        in_valid <= 1'b0;

        while (frames_due.size() != 0)
            @(posedge clk);
        repeat (2 * DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ sim.f @@
design/sssd_pkg.sv
design/sssd_decimal.sv
design/seven_segment_scan_driver.sv
sim/seven_segment_scan_driver_test.sv
